@@ sv/tsrc_pkg.sv @@
package tsrc_pkg;

   // Defaults of the top-level parameters
   localparam int unsigned DEF_QUEUE_DEPTH = 16;
   localparam int unsigned DEF_MAX_PAYLOAD = 1452;

   // Result buffer for one item
   localparam int unsigned MAX_RES   = 16;
   localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
   localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

   // Command codes
   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_END   = 3'd1;
   localparam logic [2:0] CMD_ACK   = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_EMPTY = 3'd4;

   // Register map
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ISN      = 2'd0;
   localparam logic [1:0] REG_TIMEOUT  = 2'd1;
   localparam logic [1:0] REG_CAPACITY = 2'd2;

   localparam logic [15:0] RESET_TIMEOUT  = 16'd1000;
   localparam logic [15:0] RESET_CAPACITY = 16'd65000;

   typedef struct packed {
      logic load;
      logic exec;
      logic ack_cmp;
      logic ack_upd;
      logic ret_chk;
      logic tick_chk;
      logic fill_a;
      logic fill_b;
      logic fill_c;
      logic fill_end;
      logic drain_adv;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic       ack_bad;
      logic       can_fill;
      logic       fill_go;
      logic       ret_ok;
      logic       drain_last;
   } dp_stat_type;

   typedef struct packed {
      logic [31:0] seqno;
      logic        syn;
      logic        fin;
      logic [10:0] pay;
      logic [31:0] offset;
      logic        retx;
   } result_type;

endpackage

@@ sv/tsrc_if.sv @@
interface tsrc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [15:0] byte_count;
   logic [31:0] ack_number;
   logic [15:0] advertised_window;
   logic [15:0] elapsed_ms;

   modport source (output valid, command, byte_count, ack_number, advertised_window,
                   elapsed_ms, input ready);
   modport sink (input valid, command, byte_count, ack_number, advertised_window,
                 elapsed_ms, output ready);
endinterface

interface tsrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        segment_valid;
   logic [31:0] seqno;
   logic        syn_flag;
   logic        fin_flag;
   logic [10:0] payload_length;
   logic [31:0] stream_offset;
   logic        is_retransmit;
   logic        ack_valid;
   logic [7:0]  retransmit_count;
   logic [16:0] in_flight_bytes;
   logic        last;

   modport source (output valid, segment_valid, seqno, syn_flag, fin_flag, payload_length,
                   stream_offset, is_retransmit, ack_valid, retransmit_count,
                   in_flight_bytes, last, input ready);
   modport sink (input valid, segment_valid, seqno, syn_flag, fin_flag, payload_length,
                 stream_offset, is_retransmit, ack_valid, retransmit_count,
                 in_flight_bytes, last, output ready);
endinterface

@@ sv/tcp_sender_retransmit_ctrl.sv @@
// TCP sender sequence and retransmission control on segment descriptors. Each request
// transfer carries one command (bytes written, input ended, ack, timer tick, empty segment
// request); the block answers with one or more response transfers, the final one flagged
// by last, and takes the next request only after that final response has been taken.
// A command that produces no segment gives a single status response. Every response of
// one command carries the status values (ack_valid, retransmit_count, in_flight_bytes)
// as they stand at the end of that command. Each command is accepted and decoded; a
// tick then checks the timer; an ack compares and updates, and a valid one then checks
// and retires the ring head one entry at a time until a head check fails (the
// outstanding ring is read through a registered memory port); write, end and valid
// acks then run the window-fill loop, one emitted segment per pass through its fill_a,
// fill_b and fill_c steps, until the loop finds it is done and closes it in fill_end;
// then the responses go out one per cycle while the receiver is ready. Configuration
// goes through the APB port (initial_seqno at 0x0, initial_timeout_ms at 0x4,
// stream_capacity at 0x8) while idle; the user must see to this, the block does not.
module tcp_sender_retransmit_ctrl
   import tsrc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
)(
   input  logic                  clock,
   input  logic                  reset,
   tsrc_req_if.sink              req_chan,
   tsrc_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   result_type  res;
   logic        req_fire, rsp_fire;
   logic        req_ready, rsp_valid;
   logic        csr_wr;
   logic        seg_valid;

   // A transfer completes when both sides agree
   assign req_fire = req_chan.valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_chan.ready;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   tsrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_fire  (rsp_fire),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   tsrc_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .in_command           (req_chan.command),
      .in_byte_count        (req_chan.byte_count),
      .in_ack_number        (req_chan.ack_number),
      .in_advertised_window (req_chan.advertised_window),
      .in_elapsed_ms        (req_chan.elapsed_ms),
      .out_res              (res),
      .out_ack_valid        (rsp_chan.ack_valid),
      .out_retx_count       (rsp_chan.retransmit_count),
      .out_in_flight        (rsp_chan.in_flight_bytes),
      .out_last             (rsp_chan.last),
      .out_seg_valid        (seg_valid),
      .csr_wr               (csr_wr),
      .csr_idx              (paddr[3:2]),
      .csr_wdata            (pwdata),
      .csr_rdata            (prdata)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // Status responses carry a zero descriptor and segment_valid low
   assign rsp_chan.segment_valid  = seg_valid;
   assign rsp_chan.seqno          = res.seqno;
   assign rsp_chan.syn_flag       = res.syn;
   assign rsp_chan.fin_flag       = res.fin;
   assign rsp_chan.payload_length = res.pay;
   assign rsp_chan.stream_offset  = res.offset;
   assign rsp_chan.is_retransmit  = res.retx;

`ifndef SYNTHESIS
   // Never take a request while responses are pending
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && req_ready))
      else $error("request taken while responses pending");
   // After a request transfer the block is not ready in the next cycle
   assert property (@(posedge clock) disable iff (reset) req_fire |=> !req_ready)
      else $error("ready high right after request transfer");
   // The final response frees the block
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_fire && rsp_chan.last) |=> req_ready)
      else $error("block not idle after final response");
   // Empty segment requests always yield a segment
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && stat.command == CMD_EMPTY) |-> rsp_chan.segment_valid)
      else $error("empty segment request without segment");
`endif

endmodule

@@ sv/tsrc_ctrl.sv @@
module tsrc_ctrl
   import tsrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  logic        rsp_fire,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        req_ready,
   output logic        rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_ACK_CMP, ST_ACK_UPD, ST_RET_WAIT, ST_RET_CHK, ST_TICK_CHK,
      ST_FILL_A, ST_FILL_B, ST_FILL_C, ST_FILL_END, ST_DRAIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_fire;
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (stat.command)
               CMD_WRITE, CMD_END: state_in = ST_FILL_A;
               CMD_ACK:            state_in = ST_ACK_CMP;
               CMD_TICK:           state_in = ST_TICK_CHK;
               default:            state_in = ST_DRAIN;
            endcase
         end
         ST_ACK_CMP: begin
            cmd.ack_cmp = 1'b1;
            state_in    = ST_ACK_UPD;
         end
         ST_ACK_UPD: begin
            cmd.ack_upd = 1'b1;
            state_in    = stat.ack_bad ? ST_DRAIN : ST_RET_WAIT;
         end
         ST_RET_WAIT: state_in = ST_RET_CHK;
         ST_RET_CHK: begin
            cmd.ret_chk = 1'b1;
            state_in    = stat.ret_ok ? ST_RET_WAIT : ST_FILL_A;
         end
         ST_TICK_CHK: begin
            cmd.tick_chk = 1'b1;
            state_in     = ST_DRAIN;
         end
         ST_FILL_A: begin
            cmd.fill_a = 1'b1;
            state_in   = stat.can_fill ? ST_FILL_B : ST_FILL_END;
         end
         ST_FILL_B: begin
            cmd.fill_b = 1'b1;
            state_in   = ST_FILL_C;
         end
         ST_FILL_C: begin
            cmd.fill_c = 1'b1;
            state_in   = stat.fill_go ? ST_FILL_A : ST_FILL_END;
         end
         ST_FILL_END: begin
            cmd.fill_end = 1'b1;
            state_in     = ST_DRAIN;
         end
         ST_DRAIN: begin
            rsp_valid     = 1'b1;
            cmd.drain_adv = rsp_fire;
            if (rsp_fire && stat.drain_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/tsrc_dp.sv @@
module tsrc_dp
   import tsrc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int unsigned MAX_PAYLOAD = DEF_MAX_PAYLOAD
)(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [2:0]  in_command,
   input  logic [15:0] in_byte_count,
   input  logic [31:0] in_ack_number,
   input  logic [15:0] in_advertised_window,
   input  logic [15:0] in_elapsed_ms,
   output result_type  out_res,
   output logic        out_ack_valid,
   output logic [7:0]  out_retx_count,
   output logic [16:0] out_in_flight,
   output logic        out_last,
   output logic        out_seg_valid,
   input  logic        csr_wr,
   input  logic [1:0]  csr_idx,
   input  logic [31:0] csr_wdata,
   output logic [31:0] csr_rdata
);

   localparam int unsigned RING_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned RING_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [RING_IDX_W-1:0] RING_LAST = RING_IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [RING_CNT_W-1:0] RING_FULL = RING_CNT_W'(QUEUE_DEPTH);
   localparam logic [15:0] PAY_MAX = 16'(MAX_PAYLOAD);
   localparam logic [RES_CNT_W-1:0] RES_FULL = RES_CNT_W'(MAX_RES);

   typedef struct packed {
      logic [63:0] start;
      logic [10:0] len;
      logic        syn;
      logic        fin;
   } ring_entry_type;

   // Configuration
   logic [31:0] isn_ff;
   logic [15:0] init_to_ff, cap_ff;
   // Latched item
   logic [2:0]  cmd_ff;
   logic [15:0] cnt_ff, win_ff, ms_ff;
   logic [31:0] ackn_ff;
   // Connection state
   logic [63:0] next_ff, acked_ff, wedge_ff;
   logic        lwn_ff, done_ff, syn_sent_ff, fin_sent_ff, tact_ff;
   logic [15:0] buf_ff;
   logic [31:0] tcnt_ff, cto_ff;
   logic [7:0]  retx_ff;
   logic [RING_IDX_W-1:0] head_ff, tail_ff;
   logic [RING_CNT_W-1:0] used_ff;
   logic        ack_ok_ff;
   // Step scratch
   logic [63:0] a_ff, esum_ff, edge_ff;
   logic        gt_ff, ge_ff, room_ff;
   logic [16:0] free_ff;
   logic [RES_CNT_W-1:0] res_cnt_ff;
   logic [RES_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   result_type     res_mem [MAX_RES];
   result_type     res_rd_ff;
   ring_entry_type ring_mem [QUEUE_DEPTH];
   ring_entry_type ring_rd_ff;

   // Ack unwrap
   logic [31:0] off_w, ndiff_w;
   logic [32:0] diff_w;
   logic        down_w, up_w;
   logic [63:0] a_in;
   always_comb begin
      off_w   = ackn_ff - isn_ff;
      diff_w  = {1'b0, off_w} - {1'b0, next_ff[31:0]};
      ndiff_w = next_ff[31:0] - off_w;
      down_w  = !diff_w[32] && (diff_w[31:0] > 32'h8000_0000) && (next_ff[63:32] != 32'd0);
      up_w    = diff_w[32] && (ndiff_w > 32'h8000_0000);
      if (down_w)      a_in = {next_ff[63:32] - 32'd1, off_w};
      else if (up_w)   a_in = {next_ff[63:32] + 32'd1, off_w};
      else             a_in = {next_ff[63:32], off_w};
   end

   // Retire check on the head entry
   logic [63:0] ret_end_w;
   logic        ret_ok_w;
   assign ret_end_w = ring_rd_ff.start + {53'd0, ring_rd_ff.len};
   assign ret_ok_w  = (used_ff != '0) && (ret_end_w <= acked_ff);

   // Segment cut
   logic [15:0] pay1_w;
   logic [16:0] pay2_w, free_w;
   logic [63:0] fdiff_w;
   logic [10:0] pay_w, len_w;
   logic        seg_fin_w, fill_go_w;
   always_comb begin
      pay1_w    = (buf_ff > PAY_MAX) ? PAY_MAX : buf_ff;
      pay2_w    = ({1'b0, pay1_w} > free_ff) ? free_ff : {1'b0, pay1_w};
      pay_w     = syn_sent_ff ? pay2_w[10:0] : 11'd0;
      seg_fin_w = syn_sent_ff && done_ff && (pay2_w == {1'b0, buf_ff}) && (pay2_w < free_ff);
      fill_go_w = room_ff && (!syn_sent_ff ||
                              (!fin_sent_ff && ((pay2_w != 17'd0) || seg_fin_w)));
      len_w     = pay_w + {10'd0, !syn_sent_ff} + {10'd0, seg_fin_w};
      fdiff_w   = edge_ff - next_ff;
      free_w    = (|fdiff_w[63:17]) ? '1 : fdiff_w[16:0];
   end

   // Timer
   logic [32:0] tsum_w;
   logic        fire_w;
   assign tsum_w = {1'b0, tcnt_ff} + {17'd0, ms_ff};
   assign fire_w = cmd.tick_chk && tact_ff && (tcnt_ff >= cto_ff) && (used_ff != '0);

   // Result write port
   logic       emit_w, fill_w;
   result_type emit_res_w;
   assign fill_w = cmd.fill_c && fill_go_w;
   always_comb begin
      emit_w     = 1'b0;
      emit_res_w = '0;
      if (fill_w) begin
         emit_w            = 1'b1;
         emit_res_w.seqno  = isn_ff + next_ff[31:0];
         emit_res_w.syn    = !syn_sent_ff;
         emit_res_w.fin    = seg_fin_w;
         emit_res_w.pay    = pay_w;
         emit_res_w.offset = syn_sent_ff ? next_ff[31:0] - 32'd1 : 32'd0;
      end else if (fire_w) begin
         emit_w            = 1'b1;
         emit_res_w.seqno  = isn_ff + ring_rd_ff.start[31:0];
         emit_res_w.syn    = ring_rd_ff.syn;
         emit_res_w.fin    = ring_rd_ff.fin;
         emit_res_w.pay    = ring_rd_ff.len - {10'd0, ring_rd_ff.syn}
                             - {10'd0, ring_rd_ff.fin};
         emit_res_w.offset = ring_rd_ff.syn ? 32'd0 : ring_rd_ff.start[31:0] - 32'd1;
         emit_res_w.retx   = 1'b1;
      end else if (cmd.exec && cmd_ff == CMD_EMPTY) begin
         emit_w            = 1'b1;
         emit_res_w.seqno  = isn_ff + next_ff[31:0];
         emit_res_w.offset = next_ff[31:0] - {31'd0, syn_sent_ff} - {31'd0, fin_sent_ff};
      end
   end

   // Read address for the next cycle; a result written to it passes straight through
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.load) rd_ptr_in = '0;
      else if (cmd.drain_adv) rd_ptr_in = rd_ptr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (emit_w) res_mem[res_cnt_ff[RES_IDX_W-1:0]] <= emit_res_w;
      if (emit_w && res_cnt_ff[RES_IDX_W-1:0] == rd_ptr_in) res_rd_ff <= emit_res_w;
      else res_rd_ff <= res_mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (fill_w) ring_mem[tail_ff] <= '{start: next_ff, len: len_w, syn: !syn_sent_ff,
                                         fin: seg_fin_w};
      ring_rd_ff <= ring_mem[head_ff];
   end

   logic [16:0] wsum_w;
   assign wsum_w = {1'b0, buf_ff} + {1'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         isn_ff      <= '0;
         init_to_ff  <= RESET_TIMEOUT;
         cap_ff      <= RESET_CAPACITY;
         cmd_ff      <= CMD_WRITE;
         next_ff     <= '0;
         acked_ff    <= '0;
         wedge_ff    <= 64'd1;
         lwn_ff      <= 1'b1;
         done_ff     <= 1'b0;
         syn_sent_ff <= 1'b0;
         fin_sent_ff <= 1'b0;
         tact_ff     <= 1'b0;
         buf_ff      <= '0;
         tcnt_ff     <= '0;
         cto_ff      <= {16'd0, RESET_TIMEOUT};
         retx_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         used_ff     <= '0;
         ack_ok_ff   <= 1'b1;
         res_cnt_ff  <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         if (csr_wr) begin
            case (csr_idx)
               REG_ISN: isn_ff <= csr_wdata;
               REG_TIMEOUT: begin
                  init_to_ff <= csr_wdata[15:0];
                  if (used_ff == '0) cto_ff <= {16'd0, csr_wdata[15:0]};
               end
               REG_CAPACITY: cap_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            cmd_ff     <= in_command;
            res_cnt_ff <= '0;
            rd_ptr_ff  <= '0;
            ack_ok_ff  <= 1'b1;
         end
         if (cmd.exec) begin
            case (cmd_ff)
               CMD_WRITE: begin
                  if (!done_ff) buf_ff <= (wsum_w > {1'b0, cap_ff}) ? cap_ff : wsum_w[15:0];
               end
               CMD_END: done_ff <= 1'b1;
               CMD_TICK: begin
                  if (tact_ff) tcnt_ff <= tsum_w[32] ? '1 : tsum_w[31:0];
               end
               default: ;
            endcase
         end
         if (cmd.ack_upd && !gt_ff) begin
            if (ge_ff) begin
               acked_ff <= a_ff;
               wedge_ff <= esum_ff;
               lwn_ff   <= win_ff != 16'd0;
            end
         end
         if (cmd.ack_upd && gt_ff) ack_ok_ff <= 1'b0;
         if (cmd.ret_chk && ret_ok_w) begin
            head_ff <= (head_ff == RING_LAST) ? '0 : head_ff + 1'b1;
            used_ff <= used_ff - 1'b1;
            cto_ff  <= {16'd0, init_to_ff};
            retx_ff <= '0;
            tcnt_ff <= '0;
         end
         if (fire_w) begin
            if (lwn_ff) begin
               if (retx_ff != 8'hFF) retx_ff <= retx_ff + 8'd1;
               cto_ff <= cto_ff[31] ? '1 : {cto_ff[30:0], 1'b0};
            end
            tcnt_ff <= '0;
         end
         if (fill_w) begin
            tail_ff     <= (tail_ff == RING_LAST) ? '0 : tail_ff + 1'b1;
            used_ff     <= used_ff + 1'b1;
            next_ff     <= next_ff + {53'd0, len_w};
            buf_ff      <= buf_ff - {5'd0, pay_w};
            syn_sent_ff <= 1'b1;
            if (seg_fin_w) fin_sent_ff <= 1'b1;
            if (!tact_ff) begin
               tact_ff <= 1'b1;
               tcnt_ff <= '0;
            end
         end
         if (cmd.fill_end && cmd_ff == CMD_ACK && used_ff == '0) tact_ff <= 1'b0;
         if (emit_w) res_cnt_ff <= res_cnt_ff + 1'b1;
         if (cmd.drain_adv) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   // Item payload and step scratch, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff  <= in_byte_count;
         ackn_ff <= in_ack_number;
         win_ff  <= in_advertised_window;
         ms_ff   <= in_elapsed_ms;
      end
      if (cmd.exec) a_ff <= a_in;
      if (cmd.ack_cmp) begin
         gt_ff   <= a_ff > next_ff;
         ge_ff   <= a_ff >= acked_ff;
         esum_ff <= a_ff + {48'd0, win_ff};
      end
      if (cmd.fill_a) edge_ff <= wedge_ff + {63'd0, !lwn_ff};
      if (cmd.fill_b) begin
         room_ff <= edge_ff > next_ff;
         free_ff <= free_w;
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ISN:      csr_rdata = isn_ff;
         REG_TIMEOUT:  csr_rdata = {16'd0, init_to_ff};
         REG_CAPACITY: csr_rdata = {16'd0, cap_ff};
         default:      csr_rdata = 32'd0;
      endcase
   end

   assign stat.command    = cmd_ff;
   assign stat.ack_bad    = gt_ff;
   assign stat.can_fill   = (res_cnt_ff < RES_FULL) && (used_ff < RING_FULL);
   assign stat.fill_go    = fill_go_w;
   assign stat.ret_ok     = ret_ok_w;
   assign stat.drain_last = out_last;

   assign out_seg_valid  = (res_cnt_ff != '0);
   assign out_res        = (res_cnt_ff == '0) ? '0 : res_rd_ff;
   assign out_last       = (res_cnt_ff == '0) || ({1'b0, rd_ptr_ff} == res_cnt_ff - 1'b1);
   assign out_ack_valid  = ack_ok_ff;
   assign out_retx_count = retx_ff;
   assign out_in_flight  = next_ff[16:0] - acked_ff[16:0];

endmodule

@@ tb/tcp_sender_retransmit_ctrl_test.sv @@
`timescale 1ns / 100ps

module tcp_sender_retransmit_ctrl_test;
   import tsrc_pkg::*;

   localparam int RING_DEPTH = DEF_QUEUE_DEPTH;
   localparam int SEG_MAX    = DEF_MAX_PAYLOAD;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT = 800000;

   typedef struct {
      logic        segment_valid;
      logic [31:0] seqno;
      logic        syn_flag;
      logic        fin_flag;
      logic [10:0] payload_length;
      logic [31:0] stream_offset;
      logic        is_retransmit;
      logic        ack_valid;
      logic [7:0]  retransmit_count;
      logic [16:0] in_flight_bytes;
      logic        last;
   } segment_desc_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   tsrc_req_if req ();
   tsrc_rsp_if rsp ();

   tcp_sender_retransmit_ctrl dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Expected response descriptors, oldest first
   segment_desc_type expected_segs[$];
   segment_desc_type step_segs[$];
   int error_count;
   int cycle_count;
   int burst_left;
   int rx_mode;
   bit hold_go;
   bit rsp_hold;

   // Shadow of the sender: configuration
   logic [31:0] isn_cfg;
   logic [15:0] rto_init_cfg;
   logic [15:0] capacity_cfg;
   // Shadow of the sender: sequence and timer state
   logic [63:0] next_seq, acked_seq, win_edge;
   bit          win_open, stream_closed, syn_done, fin_done, timer_on;
   logic [31:0] buffered;
   logic [31:0] timer_ms, rto_ms;
   logic [7:0]  retx_n;
   logic [63:0] ring_start[RING_DEPTH];
   logic [10:0] ring_len[RING_DEPTH];
   logic [1:0]  ring_flg[RING_DEPTH];
   int          ring_head, ring_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic void add_seg(logic [63:0] seq, logic [10:0] pay, logic [1:0] flags,
                                   logic [63:0] off, bit retx);
      segment_desc_type s;
      s.segment_valid  = 1'b1;
      s.seqno          = isn_cfg + seq[31:0];
      s.syn_flag       = flags[0];
      s.fin_flag       = flags[1];
      s.payload_length = pay;
      s.stream_offset  = off[31:0];
      s.is_retransmit  = retx;
      step_segs.insert(step_segs.size(), s);
   endfunction

   // Cut new segments into the free window
   function automatic void cut_segments();
      logic [63:0] right_edge, free_sp, pay;
      logic [1:0]  flags;
      logic [10:0] len;
      int          slot;
      while (step_segs.size() < MAX_RES && ring_used < RING_DEPTH) begin
         right_edge = win_edge + (win_open ? 64'd0 : 64'd1);
         if (right_edge <= next_seq) break;
         free_sp = right_edge - next_seq;
         pay = 0;
         flags = 2'b00;
         if (!syn_done) begin
            flags = 2'b01;
         end else begin
            if (fin_done) break;
            pay = buffered;
            if (pay > SEG_MAX) pay = SEG_MAX;
            if (pay > free_sp) pay = free_sp;
            if (stream_closed && pay == buffered && pay < free_sp) flags = 2'b10;
            if (pay == 0 && flags == 2'b00) break;
         end
         len = pay[10:0] + {10'd0, flags[0]} + {10'd0, flags[1]};
         slot = (ring_head + ring_used) % RING_DEPTH;
         ring_start[slot] = next_seq;
         ring_len[slot] = len;
         ring_flg[slot] = flags;
         ring_used++;
         add_seg(next_seq, pay[10:0], flags, flags[0] ? 64'd0 : next_seq - 1, 1'b0);
         next_seq += {53'd0, len};
         buffered -= pay[31:0];
         if (flags[0]) syn_done = 1'b1;
         if (flags[1]) fin_done = 1'b1;
         if (!timer_on) begin
            timer_on = 1'b1;
            timer_ms = 0;
         end
      end
   endfunction

   function automatic logic [63:0] unwrap_ack(logic [31:0] ackw);
      logic [31:0] off;
      logic [63:0] c;
      off = ackw - isn_cfg;
      c = {next_seq[63:32], off};
      if (c > next_seq && c - next_seq > 64'h8000_0000 && c >= 64'h1_0000_0000)
         c -= 64'h1_0000_0000;
      else if (c < next_seq && next_seq - c > 64'h8000_0000)
         c += 64'h1_0000_0000;
      return c;
   endfunction

   function automatic bit apply_ack(logic [31:0] ackw, logic [15:0] win);
      logic [63:0] a;
      bit          retired;
      int          h;
      a = unwrap_ack(ackw);
      retired = 1'b0;
      if (a > next_seq) return 1'b0;
      if (a >= acked_seq) begin
         acked_seq = a;
         win_edge = a + {48'd0, win};
         win_open = (win != 0);
      end
      while (ring_used > 0) begin
         h = ring_head;
         if (ring_start[h] + {53'd0, ring_len[h]} > acked_seq) break;
         ring_head = (h + 1) % RING_DEPTH;
         ring_used--;
         retired = 1'b1;
      end
      if (retired) begin
         rto_ms = {16'd0, rto_init_cfg};
         retx_n = 0;
         timer_ms = 0;
      end
      cut_segments();
      if (ring_used == 0) timer_on = 1'b0;
      return 1'b1;
   endfunction

   function automatic void apply_tick(logic [15:0] ms);
      int h;
      if (!timer_on) return;
      timer_ms = (timer_ms > 32'hFFFF_FFFF - {16'd0, ms}) ? 32'hFFFF_FFFF
                                                          : timer_ms + {16'd0, ms};
      if (timer_ms < rto_ms || ring_used == 0) return;
      h = ring_head;
      add_seg(ring_start[h], ring_len[h] - {10'd0, ring_flg[h][0]} - {10'd0, ring_flg[h][1]},
              ring_flg[h], ring_flg[h][0] ? 64'd0 : ring_start[h] - 1, 1'b1);
      if (win_open) begin
         if (retx_n < 8'd255) retx_n++;
         rto_ms = (rto_ms > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {rto_ms[30:0], 1'b0};
      end
      timer_ms = 0;
   endfunction

   // Advance the shadow by one command and queue the responses it causes
   function automatic void predict_segments(logic [2:0] cmd, logic [15:0] cnt,
                                            logic [31:0] ackw, logic [15:0] win,
                                            logic [15:0] ms);
      bit               ack_ok;
      logic [31:0]      sum;
      segment_desc_type s;
      ack_ok = 1'b1;
      step_segs.delete();
      case (cmd)
         CMD_WRITE: begin
            if (!stream_closed) begin
               sum = buffered + {16'd0, cnt};
               buffered = (sum > {16'd0, capacity_cfg}) ? {16'd0, capacity_cfg} : sum;
            end
            cut_segments();
         end
         CMD_END: begin
            stream_closed = 1'b1;
            cut_segments();
         end
         CMD_ACK:   ack_ok = apply_ack(ackw, win);
         CMD_TICK:  apply_tick(ms);
         CMD_EMPTY: add_seg(next_seq, 11'd0, 2'b00,
                            next_seq - {63'd0, syn_done} - {63'd0, fin_done}, 1'b0);
         default: ;
      endcase
      if (step_segs.size() == 0) begin
         s = '{default: '0};
         step_segs.insert(0, s);
      end
      foreach (step_segs[k]) begin
         s = step_segs[k];
         s.ack_valid = ack_ok;
         s.retransmit_count = retx_n;
         s.in_flight_bytes = next_seq[16:0] - acked_seq[16:0];
         s.last = (k == step_segs.size() - 1);
         expected_segs.insert(expected_segs.size(), s);
      end
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, field, got, want);
      error_count++;
   endtask

   task automatic check_segment();
      segment_desc_type e;
      if (expected_segs.size() == 0) begin
         report_mismatch("unexpected response transfer", 32'd1, 32'd0);
         return;
      end
      e = expected_segs.pop_front();
      if (rsp.segment_valid !== e.segment_valid)
         report_mismatch("segment_valid", 32'(rsp.segment_valid), 32'(e.segment_valid));
      if (rsp.seqno !== e.seqno) report_mismatch("seqno", rsp.seqno, e.seqno);
      if (rsp.syn_flag !== e.syn_flag)
         report_mismatch("syn_flag", 32'(rsp.syn_flag), 32'(e.syn_flag));
      if (rsp.fin_flag !== e.fin_flag)
         report_mismatch("fin_flag", 32'(rsp.fin_flag), 32'(e.fin_flag));
      if (rsp.payload_length !== e.payload_length)
         report_mismatch("payload_length", 32'(rsp.payload_length), 32'(e.payload_length));
      if (rsp.stream_offset !== e.stream_offset)
         report_mismatch("stream_offset", rsp.stream_offset, e.stream_offset);
      if (rsp.is_retransmit !== e.is_retransmit)
         report_mismatch("is_retransmit", 32'(rsp.is_retransmit), 32'(e.is_retransmit));
      if (rsp.ack_valid !== e.ack_valid)
         report_mismatch("ack_valid", 32'(rsp.ack_valid), 32'(e.ack_valid));
      if (rsp.retransmit_count !== e.retransmit_count)
         report_mismatch("retransmit_count", 32'(rsp.retransmit_count),
                         32'(e.retransmit_count));
      if (rsp.in_flight_bytes !== e.in_flight_bytes)
         report_mismatch("in_flight_bytes", 32'(rsp.in_flight_bytes),
                         32'(e.in_flight_bytes));
      if (rsp.last !== e.last) report_mismatch("last", 32'(rsp.last), 32'(e.last));
   endtask

   // Response side: check every transfer, stall on a pattern that changes mode now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) check_segment();
         if (cycle_count % 97 == 0) rx_mode = $urandom_range(0, 2);
         case (rx_mode)
            0: rsp.ready <= !rsp_hold;
            1: rsp.ready <= !rsp_hold && (cycle_count % 7 >= 3);
            default: rsp.ready <= !rsp_hold && ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Long hold-off of the response side, counted here
   always begin
      wait (hold_go);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
      hold_go = 1'b0;
   end

   // Offer one command and hold it until the transfer; then maybe drop valid for a gap.
   // Entered and left at a rising edge.
   task automatic send_command(logic [2:0] cmd, logic [15:0] cnt, logic [31:0] ackw,
                               logic [15:0] win, logic [15:0] ms);
      int gap;
      req.valid             <= 1'b1;
      req.command           <= cmd;
      req.byte_count        <= cnt;
      req.ack_number        <= ackw;
      req.advertised_window <= win;
      req.elapsed_ms        <= ms;
      do @(posedge clock); while (!req.ready);
      predict_segments(cmd, cnt, ackw, win, ms);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 10);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drain all pending responses, then let trailing work settle
   task automatic wait_idle();
      req.valid <= 1'b0;
      @(posedge clock);
      wait (expected_segs.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_ISN:     isn_cfg = value;
         REG_TIMEOUT: begin
            rto_init_cfg = value[15:0];
            if (ring_used == 0) rto_ms = {16'd0, rto_init_cfg};
         end
         REG_CAPACITY: capacity_cfg = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] isn, logic [15:0] rto, logic [15:0] cap);
      wait_idle();
      csr_write(REG_ISN, isn);
      csr_write(REG_TIMEOUT, {16'd0, rto});
      csr_write(REG_CAPACITY, {16'd0, cap});
   endtask

   // Ack somewhere between the acked and next sequence numbers, often the whole flight
   function automatic logic [31:0] plausible_ack();
      logic [63:0] span, a;
      span = next_seq - acked_seq;
      if ($urandom_range(0, 9) < 4) a = next_seq;
      else a = acked_seq + {32'd0, $urandom_range(0, span[31:0])};
      return isn_cfg + a[31:0];
   endfunction

   function automatic logic [15:0] random_window();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(1, 3000));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_directed();
      send_command(CMD_TICK, 0, 0, 0, 16'hFFFF);          // timer idle
      send_command(CMD_ACK, 0, 32'hFFFF_FFFF, 100, 0);    // ack beyond anything sent
      send_command(CMD_EMPTY, 0, 0, 0, 0);
      send_command(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_command(3'd7, 0, 0, 0, 0);
      send_command(CMD_WRITE, 16'd0, 0, 0, 0);            // SYN goes out alone
      send_command(CMD_WRITE, 16'hFFFF, 0, 0, 0);         // saturates at capacity
      send_command(CMD_TICK, 0, 0, 0, 16'd999);
      send_command(CMD_TICK, 0, 0, 0, 16'd1);             // SYN resent
      send_command(CMD_ACK, 0, isn_cfg + 1, 16'hFFFF, 0); // big window, full fill
      send_command(CMD_EMPTY, 0, 0, 0, 0);
      send_command(CMD_ACK, 0, isn_cfg, 16'd10, 0);       // stale ack
      send_command(CMD_ACK, 0, isn_cfg + next_seq[31:0], 16'd0, 0);   // zero window
      send_command(CMD_WRITE, 16'd5, 0, 0, 0);            // one-byte probe
      send_command(CMD_TICK, 0, 0, 0, 16'hFFFF);          // resend, no backoff
      send_command(CMD_ACK, 0, isn_cfg + next_seq[31:0], 16'd1, 0);
      send_command(CMD_TICK, 0, 0, 0, 16'hFFFF);
      send_command(CMD_TICK, 0, 0, 0, 16'hFFFF);          // backoff doubles
      send_command(CMD_ACK, 0, plausible_ack(), 16'd1452, 0);
      send_command(CMD_ACK, 0, isn_cfg + next_seq[31:0], 16'd3000, 0);
   endtask

   task automatic test_random(int count, bit allow_end);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 30)
            send_command(CMD_WRITE, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                         : 16'($urandom_range(0, 3000)), $urandom, 16'($urandom),
                         16'($urandom));
         else if (r < 65)
            send_command(CMD_ACK, 16'($urandom), plausible_ack(), random_window(),
                         16'($urandom));
         else if (r < 80)
            send_command(CMD_TICK, 16'($urandom), $urandom, 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                         : 16'($urandom_range(0, 700)));
         else if (r < 86)
            send_command(CMD_EMPTY, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
         else if (r < 90 && allow_end)
            send_command(CMD_END, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
         else if (r < 95)
            send_command(CMD_ACK, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
         else
            send_command(3'($urandom_range(5, 7)), 16'($urandom), $urandom, 16'($urandom),
                         16'($urandom));
      end
   endtask

   // Hold the response side for a long stretch while commands keep coming
   task automatic test_backpressure();
      hold_go = 1'b1;
      repeat (30)
         send_command(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_EMPTY,
                      16'($urandom_range(1, 2000)), 0, 0, 0);
      send_command(CMD_ACK, 0, plausible_ack(), 16'hFFFF, 0);
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req.valid = 1'b0; req.command = CMD_WRITE; req.byte_count = '0;
      req.ack_number = '0; req.advertised_window = '0; req.elapsed_ms = '0;
      error_count = 0; cycle_count = 0; burst_left = 0; rx_mode = 0;
      hold_go = 1'b0; rsp_hold = 1'b0;
      isn_cfg = 0; rto_init_cfg = RESET_TIMEOUT; capacity_cfg = RESET_CAPACITY;
      next_seq = 0; acked_seq = 0; win_edge = 1; win_open = 1'b1;
      stream_closed = 1'b0; syn_done = 1'b0; fin_done = 1'b0; timer_on = 1'b0;
      buffered = 0; timer_ms = 0; rto_ms = {16'd0, RESET_TIMEOUT}; retx_n = 0;
      ring_head = 0; ring_used = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(60, 1'b0);
      configure(32'hFFFF_FF00, 16'd1, 16'd1);                 // near wrap, smallest values
      test_random(50, 1'b0);
      test_backpressure();
      configure(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);           // largest values
      test_random(50, 1'b0);
      configure($urandom, 16'($urandom_range(1, 2000)), 16'($urandom_range(1, 65535)));
      test_random(60, 1'b1);
      send_command(CMD_END, 0, 0, 0, 0);
      send_command(CMD_ACK, 0, isn_cfg + next_seq[31:0], 16'hFFFF, 0);
      send_command(CMD_ACK, 0, isn_cfg + next_seq[31:0], 16'hFFFF, 0);

      wait_idle();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
